/* design/csts_pkg.sv */
`timescale 1ns / 1ps
package csts_pkg;

  localparam int ID_W   = 20;
  localparam int DOF_W  = 21;
  localparam int CRD_W  = 32;
  localparam int DIF_W  = 33;
  localparam int PRD_W  = 66;
  localparam int DET_W  = 67;
  localparam int DM_W   = 66;
  localparam int DV_W   = 32;
  localparam int M_W    = 65;
  localparam int TERM_W = 98;
  localparam int SUM_W  = 99;
  localparam int TOT_W  = 118;
  localparam int MAG_W  = 117;
  localparam int Q_W    = 64;
  localparam int REM_W  = 67;
  localparam int VAL_W  = 64;
  localparam int LANES  = 4;
  localparam int NODES  = 3;
  localparam int DOFS   = 6;
  localparam int IN_W   = 256;
  localparam int OUT_W  = 112;

  localparam int GAUSS_POINTS = 1;
  localparam int FRAC_SHIFT   = 15;

  localparam logic [2:0] LAST_IDX = 3'(DOFS - 1);

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // strain components
  localparam logic [1:0] SC_X = 2'd0;
  localparam logic [1:0] SC_Y = 2'd1;
  localparam logic [1:0] SC_S = 2'd2;

  // register indexes
  localparam logic [2:0] REG_D_XX = 3'd0;
  localparam logic [2:0] REG_D_XY = 3'd1;
  localparam logic [2:0] REG_D_XS = 3'd2;
  localparam logic [2:0] REG_D_YY = 3'd3;
  localparam logic [2:0] REG_D_YS = 3'd4;
  localparam logic [2:0] REG_D_SS = 3'd5;

  typedef struct packed {
    logic signed [DV_W-1:0] d_xx;
    logic signed [DV_W-1:0] d_xy;
    logic signed [DV_W-1:0] d_xs;
    logic signed [DV_W-1:0] d_yy;
    logic signed [DV_W-1:0] d_ys;
    logic signed [DV_W-1:0] d_ss;
  } csts_dmat_t;

  typedef struct packed {
    logic [DOF_W-1:0] row_dof;
    logic [DOF_W-1:0] col_dof;
    logic             degen;
    logic             last;
    logic             neg;
    logic [DM_W-1:0]  dm;
  } csts_meta_t;

  typedef struct packed {
    logic signed [DIF_W-1:0] v0;
    logic signed [DIF_W-1:0] v1;
    logic [DOF_W-1:0]        dof;
  } csts_ring_t;

  typedef struct packed {
    csts_meta_t       meta;
    logic             ovf;
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   lo;
  } csts_dv_t;

  function automatic logic signed [DV_W-1:0] d_pick(csts_dmat_t dm, logic [1:0] p,
                                                    logic [1:0] q);
    logic [1:0] a;
    logic [1:0] b;
    logic signed [DV_W-1:0] r;
    a = (p < q) ? p : q;
    b = (p < q) ? q : p;
    case ({a, b})
      {SC_X, SC_X}: r = dm.d_xx;
      {SC_X, SC_Y}: r = dm.d_xy;
      {SC_X, SC_S}: r = dm.d_xs;
      {SC_Y, SC_Y}: r = dm.d_yy;
      {SC_Y, SC_S}: r = dm.d_ys;
      {SC_S, SC_S}: r = dm.d_ss;
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/csts_lane.sv */
`timescale 1ns / 1ps
// one product term u * D * v, three register stages
module csts_lane (
  input  logic                                   clk,
  input  logic                                   adv,
  input  logic signed [csts_pkg::DIF_W-1:0]      u,
  input  logic signed [csts_pkg::DIF_W-1:0]      v,
  input  logic signed [csts_pkg::DV_W-1:0]       d,
  output logic signed [csts_pkg::TERM_W-1:0]     term
);

  logic signed [csts_pkg::M_W-1:0]    m_r;
  logic signed [csts_pkg::DIF_W-1:0]  u1_r;
  logic signed [csts_pkg::PRD_W-1:0]  plo_r;
  logic signed [csts_pkg::PRD_W-1:0]  phi_r;
  logic signed [csts_pkg::TERM_W-1:0] term_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      m_r    <= d * v;
      u1_r   <= u;
      plo_r  <= u1_r * $signed({1'b0, m_r[31:0]});
      phi_r  <= u1_r * $signed(m_r[csts_pkg::M_W-1:32]);
      term_r <= (csts_pkg::TERM_W'(phi_r) <<< 32) + csts_pkg::TERM_W'(plo_r);
    end
  end

  assign term = term_r;

endmodule

/* design/csts_front.sv */
`timescale 1ns / 1ps
module csts_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [csts_pkg::IN_W-1:0]           in_tdata,
  input  csts_pkg::csts_dmat_t                dmat,
  input  logic                                adv,
  output logic                                iss_valid,
  output logic signed [csts_pkg::DIF_W-1:0]   iss_u [csts_pkg::LANES],
  output logic signed [csts_pkg::DIF_W-1:0]   iss_v [csts_pkg::LANES],
  output logic signed [csts_pkg::DV_W-1:0]    iss_d [csts_pkg::LANES],
  output csts_pkg::csts_meta_t                iss_meta
);

  logic signed [csts_pkg::CRD_W-1:0] xs [csts_pkg::NODES];
  logic signed [csts_pkg::CRD_W-1:0] ys [csts_pkg::NODES];
  logic [csts_pkg::ID_W-1:0]         ids [csts_pkg::NODES];

  logic                              f1_valid_r;
  logic [csts_pkg::ID_W-1:0]         f1_id_r [csts_pkg::NODES];
  logic signed [csts_pkg::DIF_W-1:0] f1_b_r [csts_pkg::NODES];
  logic signed [csts_pkg::DIF_W-1:0] f1_c_r [csts_pkg::NODES];
  logic signed [csts_pkg::DIF_W-1:0] f1_dx1_r, f1_dy2_r, f1_dx2_r, f1_dy1_r;

  logic                              f2_valid_r;
  logic [csts_pkg::ID_W-1:0]         f2_id_r [csts_pkg::NODES];
  logic signed [csts_pkg::DIF_W-1:0] f2_b_r [csts_pkg::NODES];
  logic signed [csts_pkg::DIF_W-1:0] f2_c_r [csts_pkg::NODES];
  logic signed [csts_pkg::PRD_W-1:0] f2_p1_r, f2_p2_r;

  logic                              elem_valid_r;
  logic                              elem_degen_r;
  logic                              elem_neg_r;
  logic [csts_pkg::DM_W-1:0]         elem_dm_r;
  csts_pkg::csts_ring_t              row_r [csts_pkg::DOFS];
  csts_pkg::csts_ring_t              col_r [csts_pkg::DOFS];
  logic [2:0]                        i_r, j_r;

  logic                              l1_valid_r;
  logic signed [csts_pkg::DIF_W-1:0] l1_u_r [csts_pkg::LANES];
  logic signed [csts_pkg::DIF_W-1:0] l1_v_r [csts_pkg::LANES];
  logic signed [csts_pkg::DV_W-1:0]  l1_d_r [csts_pkg::LANES];
  csts_pkg::csts_meta_t              l1_meta_r;

  logic f1_free, f2_free, elem_load, elem_issue, elem_done, last_pos;
  logic signed [csts_pkg::DET_W-1:0] det;
  logic [1:0] p_idx [csts_pkg::LANES];
  logic [1:0] q_idx [csts_pkg::LANES];

  always_comb begin
    for (int n = 0; n < csts_pkg::NODES; n++) begin
      ids[n] = in_tdata[csts_pkg::ID_W*n +: csts_pkg::ID_W];
      xs[n]  = $signed(in_tdata[60 + 64*n +: csts_pkg::CRD_W]);
      ys[n]  = $signed(in_tdata[92 + 64*n +: csts_pkg::CRD_W]);
    end
  end

  assign last_pos   = (i_r == csts_pkg::LAST_IDX) && (j_r == csts_pkg::LAST_IDX);
  assign elem_issue = elem_valid_r && adv;
  assign elem_done  = elem_issue && last_pos;
  assign elem_load  = f2_valid_r && (!elem_valid_r || elem_done);
  assign f2_free    = !f2_valid_r || elem_load;
  assign f1_free    = !f1_valid_r || f2_free;
  assign in_tready  = f1_free;

  assign det = csts_pkg::DET_W'(f2_p1_r) - csts_pkg::DET_W'(f2_p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r   <= 1'b0;
      f2_valid_r   <= 1'b0;
      elem_valid_r <= 1'b0;
      l1_valid_r   <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      if (f1_free) begin
        f1_valid_r <= in_tvalid;
      end
      if (f2_free) begin
        f2_valid_r <= f1_valid_r;
      end
      if (elem_load) begin
        elem_valid_r <= 1'b1;
      end else if (elem_done) begin
        elem_valid_r <= 1'b0;
      end
      if (elem_load) begin
        i_r <= '0;
        j_r <= '0;
      end else if (elem_issue) begin
        if (j_r == csts_pkg::LAST_IDX) begin
          j_r <= '0;
          i_r <= i_r + 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      if (adv) begin
        l1_valid_r <= elem_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_free && in_tvalid) begin
      for (int n = 0; n < csts_pkg::NODES; n++) begin
        f1_id_r[n] <= ids[n];
        f1_b_r[n]  <= csts_pkg::DIF_W'(ys[(n+1)%3]) - csts_pkg::DIF_W'(ys[(n+2)%3]);
        f1_c_r[n]  <= csts_pkg::DIF_W'(xs[(n+2)%3]) - csts_pkg::DIF_W'(xs[(n+1)%3]);
      end
      f1_dx1_r <= csts_pkg::DIF_W'(xs[1]) - csts_pkg::DIF_W'(xs[0]);
      f1_dy2_r <= csts_pkg::DIF_W'(ys[2]) - csts_pkg::DIF_W'(ys[0]);
      f1_dx2_r <= csts_pkg::DIF_W'(xs[2]) - csts_pkg::DIF_W'(xs[0]);
      f1_dy1_r <= csts_pkg::DIF_W'(ys[1]) - csts_pkg::DIF_W'(ys[0]);
    end
    if (f2_free && f1_valid_r) begin
      f2_id_r <= f1_id_r;
      f2_b_r  <= f1_b_r;
      f2_c_r  <= f1_c_r;
      f2_p1_r <= f1_dx1_r * f1_dy2_r;
      f2_p2_r <= f1_dx2_r * f1_dy1_r;
    end
    if (elem_load) begin
      elem_degen_r <= (det == '0);
      elem_neg_r   <= det[csts_pkg::DET_W-1];
      elem_dm_r    <= det[csts_pkg::DET_W-1] ? csts_pkg::DM_W'(-det) : csts_pkg::DM_W'(det);
      for (int n = 0; n < csts_pkg::NODES; n++) begin
        row_r[2*n]   <= '{v0: f2_b_r[n], v1: f2_c_r[n], dof: {f2_id_r[n], 1'b0}};
        row_r[2*n+1] <= '{v0: f2_c_r[n], v1: f2_b_r[n], dof: {f2_id_r[n], 1'b1}};
        col_r[2*n]   <= '{v0: f2_b_r[n], v1: f2_c_r[n], dof: {f2_id_r[n], 1'b0}};
        col_r[2*n+1] <= '{v0: f2_c_r[n], v1: f2_b_r[n], dof: {f2_id_r[n], 1'b1}};
      end
    end else if (elem_issue) begin
      // columns turn every word, rows once per row
      for (int k = 0; k < csts_pkg::DOFS; k++) begin
        col_r[k] <= col_r[(k+1)%csts_pkg::DOFS];
      end
      if (j_r == csts_pkg::LAST_IDX) begin
        for (int k = 0; k < csts_pkg::DOFS; k++) begin
          row_r[k] <= row_r[(k+1)%csts_pkg::DOFS];
        end
      end
    end
  end

  // lane {s,t}: s picks the row nonzero, t the column nonzero
  always_comb begin
    for (int l = 0; l < csts_pkg::LANES; l++) begin
      p_idx[l] = l[1] ? csts_pkg::SC_S : (i_r[0] ? csts_pkg::SC_Y : csts_pkg::SC_X);
      q_idx[l] = l[0] ? csts_pkg::SC_S : (j_r[0] ? csts_pkg::SC_Y : csts_pkg::SC_X);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < csts_pkg::LANES; l++) begin
        l1_u_r[l] <= l[1] ? row_r[0].v1 : row_r[0].v0;
        l1_v_r[l] <= l[0] ? col_r[0].v1 : col_r[0].v0;
        l1_d_r[l] <= csts_pkg::d_pick(dmat, p_idx[l], q_idx[l]);
      end
      l1_meta_r.row_dof <= row_r[0].dof;
      l1_meta_r.col_dof <= col_r[0].dof;
      l1_meta_r.degen   <= elem_degen_r;
      l1_meta_r.last    <= last_pos;
      l1_meta_r.neg     <= elem_neg_r;
      l1_meta_r.dm      <= elem_dm_r;
    end
  end

  assign iss_valid = l1_valid_r;
  assign iss_u     = l1_u_r;
  assign iss_v     = l1_v_r;
  assign iss_d     = l1_d_r;
  assign iss_meta  = l1_meta_r;

  a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
    elem_valid_r && !adv && !elem_load |=> $stable(i_r) && $stable(j_r))
    else $error("entry position moved while stalled");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> f1_valid_r)
    else $error("accepted element lost at front stage");
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    adv && elem_valid_r |=> l1_valid_r)
    else $error("issue slot dropped");

endmodule

/* design/csts_merge.sv */
`timescale 1ns / 1ps
// sums the lane terms, scales, takes magnitude and sets up the divide
module csts_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                iss_valid,
  input  csts_pkg::csts_meta_t                iss_meta,
  input  logic signed [csts_pkg::TERM_W-1:0]  term [csts_pkg::LANES],
  output logic                                dv_valid,
  output csts_pkg::csts_dv_t                  dv
);

  localparam logic signed [csts_pkg::TOT_W-1:0] GP_MUL = csts_pkg::TOT_W'(csts_pkg::GAUSS_POINTS);

  logic                 d_valid_r [3];
  csts_pkg::csts_meta_t d_meta_r [3];

  logic                              s5_valid_r, s6_valid_r, s7_valid_r, s8_valid_r;
  csts_pkg::csts_meta_t              s5_meta_r, s6_meta_r, s7_meta_r;
  csts_pkg::csts_meta_t              s7_meta_nxt;
  logic signed [csts_pkg::SUM_W-1:0] s5_a_r, s5_b_r;
  logic signed [csts_pkg::TOT_W-1:0] s6_tot_r;
  logic [csts_pkg::MAG_W-1:0]        s7_mag_r;
  csts_pkg::csts_dv_t                s8_r;

  always_comb begin
    s7_meta_nxt     = s6_meta_r;
    s7_meta_nxt.neg = s6_meta_r.neg ^ s6_tot_r[csts_pkg::TOT_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        d_valid_r[k] <= 1'b0;
      end
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else if (adv) begin
      d_valid_r[0] <= iss_valid;
      d_valid_r[1] <= d_valid_r[0];
      d_valid_r[2] <= d_valid_r[1];
      s5_valid_r   <= d_valid_r[2];
      s6_valid_r   <= s5_valid_r;
      s7_valid_r   <= s6_valid_r;
      s8_valid_r   <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_meta_r[0] <= iss_meta;
      d_meta_r[1] <= d_meta_r[0];
      d_meta_r[2] <= d_meta_r[1];
      s5_meta_r   <= d_meta_r[2];
      s5_a_r      <= csts_pkg::SUM_W'(term[0]) + csts_pkg::SUM_W'(term[1]);
      s5_b_r      <= csts_pkg::SUM_W'(term[2]) + csts_pkg::SUM_W'(term[3]);
      s6_meta_r   <= s5_meta_r;
      s6_tot_r    <= ((csts_pkg::TOT_W'(s5_a_r) + csts_pkg::TOT_W'(s5_b_r)) * GP_MUL)
                     <<< csts_pkg::FRAC_SHIFT;
      s7_meta_r     <= s7_meta_nxt;
      s7_mag_r      <= s6_tot_r[csts_pkg::TOT_W-1] ? csts_pkg::MAG_W'(-s6_tot_r)
                                                   : csts_pkg::MAG_W'(s6_tot_r);
      s8_r.meta <= s7_meta_r;
      // quotient of 2^64 or more saturates either way
      s8_r.ovf  <= csts_pkg::DM_W'(s7_mag_r[csts_pkg::MAG_W-1:csts_pkg::Q_W]) >= s7_meta_r.dm;
      s8_r.rem  <= csts_pkg::REM_W'(s7_mag_r[csts_pkg::MAG_W-1:csts_pkg::Q_W]);
      s8_r.lo   <= s7_mag_r[csts_pkg::Q_W-1:0];
    end
  end

  assign dv_valid = s8_valid_r;
  assign dv       = s8_r;

endmodule

/* design/csts_div.sv */
`timescale 1ns / 1ps
// restoring divide, one quotient bit per stage, then round and saturate
module csts_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           dv_valid,
  input  csts_pkg::csts_dv_t             dv,
  output logic                           fin_valid,
  output logic [csts_pkg::DOF_W-1:0]     fin_row,
  output logic [csts_pkg::DOF_W-1:0]     fin_col,
  output logic [csts_pkg::VAL_W-1:0]     fin_val,
  output logic                           fin_degen,
  output logic                           fin_last
);

  logic               stg_valid_r [csts_pkg::Q_W];
  csts_pkg::csts_dv_t stg_r [csts_pkg::Q_W];
  csts_pkg::csts_dv_t tl;
  logic               up;
  logic [csts_pkg::Q_W:0] q1;

  function automatic csts_pkg::csts_dv_t div_step(csts_pkg::csts_dv_t s);
    logic [csts_pkg::REM_W-1:0] r_sh;
    logic                       qb;
    csts_pkg::csts_dv_t         o;
    o    = s;
    r_sh = {s.rem[csts_pkg::REM_W-2:0], s.lo[csts_pkg::Q_W-1]};
    qb   = 1'b0;
    if (r_sh >= {1'b0, s.meta.dm}) begin
      r_sh = r_sh - {1'b0, s.meta.dm};
      qb   = 1'b1;
    end
    o.rem = r_sh;
    o.lo  = {s.lo[csts_pkg::Q_W-2:0], qb};
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < csts_pkg::Q_W; k++) begin
        stg_valid_r[k] <= 1'b0;
      end
    end else if (adv) begin
      stg_valid_r[0] <= dv_valid;
      for (int k = 1; k < csts_pkg::Q_W; k++) begin
        stg_valid_r[k] <= stg_valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_r[0] <= div_step(dv);
      for (int k = 1; k < csts_pkg::Q_W; k++) begin
        stg_r[k] <= div_step(stg_r[k-1]);
      end
    end
  end

  assign tl = stg_r[csts_pkg::Q_W-1];
  // halves round away from zero
  assign up = {tl.rem[csts_pkg::REM_W-2:0], 1'b0} >= {1'b0, tl.meta.dm};
  assign q1 = {1'b0, tl.lo} + (csts_pkg::Q_W+1)'(up);

  always_comb begin
    if (tl.meta.degen) begin
      fin_val = '0;
    end else if (!tl.meta.neg) begin
      if (tl.ovf || q1 > (csts_pkg::Q_W+1)'(csts_pkg::VAL_MAX)) begin
        fin_val = csts_pkg::VAL_MAX;
      end else begin
        fin_val = q1[csts_pkg::Q_W-1:0];
      end
    end else begin
      if (tl.ovf || q1 > (csts_pkg::Q_W+1)'(csts_pkg::VAL_MIN)) begin
        fin_val = csts_pkg::VAL_MIN;
      end else begin
        fin_val = -q1[csts_pkg::Q_W-1:0];
      end
    end
  end

  assign fin_valid = stg_valid_r[csts_pkg::Q_W-1];
  assign fin_row   = tl.meta.row_dof;
  assign fin_col   = tl.meta.col_dof;
  assign fin_degen = tl.meta.degen;
  assign fin_last  = tl.meta.last;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && fin_degen |-> fin_val == '0)
    else $error("degenerate word carries a value");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && fin_last |-> fin_row[0] && fin_col[0])
    else $error("last word not at final row and column");

endmodule

/* design/triangle_element_stiffness_top.sv */
`timescale 1ns / 1ps
// Stiffness words leave one per cycle while out_tready does not stall, set by the single
// entry sequencer feeding four product lanes and a 64-stage pipelined divider.
// Stalls on out_tready freeze the whole entry pipeline; input keeps filling front stages.
// Reset (rst_n, synchronous, active low) empties the pipeline and clears all D registers.
module triangle_element_stiffness_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // node_id_a, node_id_b, node_id_c, x_a, y_a, x_b, y_b, x_c, y_c, zero pad
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_dof, col_dof, stiffness_value, zero pad
  output logic [111:0] out_tdata,
  // degenerate
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  csts_pkg::csts_dmat_t dmat_r;
  logic adv;
  logic [2:0] reg_idx;

  logic                                iss_valid;
  logic signed [csts_pkg::DIF_W-1:0]   iss_u [csts_pkg::LANES];
  logic signed [csts_pkg::DIF_W-1:0]   iss_v [csts_pkg::LANES];
  logic signed [csts_pkg::DV_W-1:0]    iss_d [csts_pkg::LANES];
  csts_pkg::csts_meta_t                iss_meta;
  logic signed [csts_pkg::TERM_W-1:0]  term [csts_pkg::LANES];
  logic                                dv_valid;
  csts_pkg::csts_dv_t                  dv;
  logic                                fin_valid, fin_degen, fin_last;
  logic [csts_pkg::DOF_W-1:0]          fin_row, fin_col;
  logic [csts_pkg::VAL_W-1:0]          fin_val;

  logic                                out_valid_r, out_degen_r, out_last_r;
  logic [csts_pkg::DOF_W-1:0]          out_row_r, out_col_r;
  logic [csts_pkg::VAL_W-1:0]          out_val_r;

  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dmat_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (reg_idx)
        csts_pkg::REG_D_XX: dmat_r.d_xx <= cfg_pwdata;
        csts_pkg::REG_D_XY: dmat_r.d_xy <= cfg_pwdata;
        csts_pkg::REG_D_XS: dmat_r.d_xs <= cfg_pwdata;
        csts_pkg::REG_D_YY: dmat_r.d_yy <= cfg_pwdata;
        csts_pkg::REG_D_YS: dmat_r.d_ys <= cfg_pwdata;
        csts_pkg::REG_D_SS: dmat_r.d_ss <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      csts_pkg::REG_D_XX: cfg_prdata = dmat_r.d_xx;
      csts_pkg::REG_D_XY: cfg_prdata = dmat_r.d_xy;
      csts_pkg::REG_D_XS: cfg_prdata = dmat_r.d_xs;
      csts_pkg::REG_D_YY: cfg_prdata = dmat_r.d_yy;
      csts_pkg::REG_D_YS: cfg_prdata = dmat_r.d_ys;
      csts_pkg::REG_D_SS: cfg_prdata = dmat_r.d_ss;
      default:            cfg_prdata = '0;
    endcase
  end

  assign adv = !out_valid_r || out_tready;

  csts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .dmat      (dmat_r),
    .adv       (adv),
    .iss_valid (iss_valid),
    .iss_u     (iss_u),
    .iss_v     (iss_v),
    .iss_d     (iss_d),
    .iss_meta  (iss_meta)
  );

  for (genvar l = 0; l < csts_pkg::LANES; l++) begin : g_lane
    csts_lane u_lane (
      .clk  (clk),
      .adv  (adv),
      .u    (iss_u[l]),
      .v    (iss_v[l]),
      .d    (iss_d[l]),
      .term (term[l])
    );
  end

  csts_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .iss_valid (iss_valid),
    .iss_meta  (iss_meta),
    .term      (term),
    .dv_valid  (dv_valid),
    .dv        (dv)
  );

  csts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .dv_valid  (dv_valid),
    .dv        (dv),
    .fin_valid (fin_valid),
    .fin_row   (fin_row),
    .fin_col   (fin_col),
    .fin_val   (fin_val),
    .fin_degen (fin_degen),
    .fin_last  (fin_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r   <= fin_row;
      out_col_r   <= fin_col;
      out_val_r   <= fin_val;
      out_degen_r <= fin_degen;
      out_last_r  <= fin_last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {6'b0, out_val_r, out_col_r, out_row_r};
  assign out_tuser[0] = out_degen_r;
  assign out_tlast    = out_last_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

endmodule
